// ===== src/gf3nb_pkg.sv =====
package gf3nb_pkg;

    localparam int unsigned LongTrits  = 64;
    localparam int unsigned ShortTrits = 32;
    localparam int unsigned ShiftWidth = 6;

    localparam logic SelShort = 1'b0;
    localparam logic SelLong  = 1'b1;

    localparam logic ModeCt = 1'b0;
    localparam logic ModeGs = 1'b1;

    typedef logic [LongTrits-1:0]  plane_t;
    typedef logic [ShiftWidth-1:0] shift_t;

    typedef struct packed {
        plane_t p0;
        plane_t p1;
    } poly_t;

    typedef struct packed {
        poly_t first;
        poly_t second;
    } poly_pair_t;

    typedef struct packed {
        logic   long_mode;
        shift_t shift;
    } twiddle_ctrl_t;

    typedef struct packed {
        logic   mode;
        shift_t shift_amount;
        plane_t first_plane0;
        plane_t first_plane1;
        plane_t second_plane0;
        plane_t second_plane1;
    } item_t;

    typedef struct packed {
        plane_t out_first_plane0;
        plane_t out_first_plane1;
        plane_t out_second_plane0;
        plane_t out_second_plane1;
    } result_t;

    function automatic plane_t rotl64(input plane_t v, input shift_t k);
        logic [2*LongTrits-1:0] wide;
        begin
            wide = {v, v} << k;
            return wide[2*LongTrits-1:LongTrits];
        end
    endfunction

    function automatic logic [ShortTrits-1:0] rotl32(input logic [ShortTrits-1:0] v,
                                                     input logic [ShiftWidth-2:0] k);
        logic [2*ShortTrits-1:0] wide;
        begin
            wide = {v, v} << k;
            return wide[2*ShortTrits-1:ShortTrits];
        end
    endfunction

    function automatic plane_t low_mask(input shift_t k);
        begin
            return ~({LongTrits{1'b1}} << k);
        end
    endfunction

    // GF(3) butterfly on the two bit planes of each trit.
    function automatic poly_pair_t plane_logic(input poly_t a, input poly_t b);
        plane_t     s;
        plane_t     d;
        poly_pair_t r;
        begin
            s = a.p1 ^ b.p0;
            d = a.p0 ^ b.p0;
            r.first.p0  = (s ^ b.p1) | d;
            r.first.p1  = (a.p0 ^ b.p1) & s;
            r.second.p0 = d | (a.p1 ^ b.p1);
            r.second.p1 = (d ^ b.p1) & s;
            return r;
        end
    endfunction

endpackage

// ===== src/gf3nb_interfaces.sv =====
interface gf3nb_item_if
    import gf3nb_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gf3nb_result_if
    import gf3nb_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gf3nb_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/gf3nb_twiddle.sv =====
module gf3nb_twiddle
    import gf3nb_pkg::*;
(
    input  twiddle_ctrl_t ctrl,
    input  poly_t         poly_in,
    output poly_t         poly_out
);

    logic [ShortTrits-1:0] neg_p1;
    logic [ShortTrits-1:0] rot0_short;
    plane_t                rot0_long;
    plane_t                wrap;
    plane_t                wrap_short;

    // Trits that wrap past the top are negated, which flips plane 1 where plane 0 is set.
    always_comb
    begin
        wrap       = low_mask(ctrl.shift);
        wrap_short = low_mask({1'b0, ctrl.shift[ShiftWidth-2:0]});
        neg_p1     = poly_in.p1[ShortTrits-1:0]
                     ^ (ctrl.shift[ShiftWidth-1] ? poly_in.p0[ShortTrits-1:0] : '0);
        rot0_long  = rotl64(poly_in.p0, ctrl.shift);
        rot0_short = rotl32(poly_in.p0[ShortTrits-1:0], ctrl.shift[ShiftWidth-2:0]);
        if (ctrl.long_mode == SelLong)
        begin
            poly_out.p0 = rot0_long;
            poly_out.p1 = rotl64(poly_in.p1, ctrl.shift) ^ (rot0_long & wrap);
        end
        else
        begin
            poly_out.p0 = {{(LongTrits-ShortTrits){1'b0}}, rot0_short};
            poly_out.p1 = {{(LongTrits-ShortTrits){1'b0}},
                           rotl32(neg_p1, ctrl.shift[ShiftWidth-2:0])
                           ^ (rot0_short & wrap_short[ShortTrits-1:0])};
        end
    end

endmodule

// ===== src/gf3_negacyclic_butterfly_core.sv =====
// Channel    | Direction | Payload
// operands   | in        | mode, shift_amount, first and second operand planes
// results    | out       | first and second result planes
// cfg        | in        | trit_count_select (one bit, always ready)
//
// One beat is accepted per cycle unless operands.ready is low; results are registered.
// The input register and the result register are parted by the plane logic and one barrel
// rotation, which set the clock period.
// Reset clears the valid flags and selects 64-trit polynomials.
// A stalled result holds in the result register while one further beat may wait in the
// input register; operands.ready falls only when both are full and results.ready is low.
module gf3_negacyclic_butterfly_core
    import gf3nb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    gf3nb_item_if.sink    operands,
    gf3nb_result_if.source results,
    gf3nb_cfg_if.sink     cfg
);

    logic       long_mode_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    item_t      in_data_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_data_reg;
    result_t    out_data_next;

    logic          advance;
    plane_t        keep;
    poly_t         first_op;
    poly_t         second_op;
    poly_pair_t    gs_pair;
    poly_pair_t    ct_pair;
    poly_t         tw_in;
    poly_t         tw_out;
    twiddle_ctrl_t tw_ctrl;

    assign advance        = !out_valid_reg || results.ready;
    assign operands.ready = !in_valid_reg || advance;
    assign cfg.ready      = 1'b1;

    assign in_valid_next  = operands.valid || (in_valid_reg && !advance);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_mode_reg <= SelLong;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                long_mode_reg <= cfg.data;
            end
            if (operands.ready)
            begin
                in_valid_reg <= in_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (operands.valid && operands.ready)
        begin
            in_data_reg <= operands.data;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign keep = (long_mode_reg == SelLong) ? {LongTrits{1'b1}}
                                             : {{(LongTrits-ShortTrits){1'b0}},
                                                {ShortTrits{1'b1}}};

    always_comb
    begin
        first_op.p0  = in_data_reg.first_plane0 & keep;
        first_op.p1  = in_data_reg.first_plane1 & keep;
        second_op.p0 = in_data_reg.second_plane0 & keep;
        second_op.p1 = in_data_reg.second_plane1 & keep;
        gs_pair      = plane_logic(second_op, first_op);
        tw_ctrl.long_mode = long_mode_reg;
        tw_ctrl.shift     = in_data_reg.shift_amount;
        tw_in = (in_data_reg.mode == ModeGs) ? gs_pair.second : second_op;
    end

    gf3nb_twiddle u_twiddle (
        .ctrl     (tw_ctrl),
        .poly_in  (tw_in),
        .poly_out (tw_out)
    );

    always_comb
    begin
        ct_pair = plane_logic(first_op, tw_out);
        if (in_data_reg.mode == ModeGs)
        begin
            out_data_next.out_first_plane0  = gs_pair.first.p0 & keep;
            out_data_next.out_first_plane1  = gs_pair.first.p1 & keep;
            out_data_next.out_second_plane0 = tw_out.p0 & keep;
            out_data_next.out_second_plane1 = tw_out.p1 & keep;
        end
        else
        begin
            out_data_next.out_first_plane0  = ct_pair.first.p0 & keep;
            out_data_next.out_first_plane1  = ct_pair.first.p1 & keep;
            out_data_next.out_second_plane0 = ct_pair.second.p0 & keep;
            out_data_next.out_second_plane1 = ct_pair.second.p1 & keep;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

endmodule

// ===== src/gf3nb_checker.sv =====
module gf3nb_checker
    import gf3nb_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    op_valid,
    input logic    op_ready,
    input logic    res_valid,
    input logic    res_ready,
    input result_t res_data,
    input logic    cfg_valid,
    input logic    cfg_ready,
    input logic    cfg_data
);

    logic       long_mode_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = op_valid && op_ready;
    assign out_beat = res_valid && res_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_beat && !out_beat)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (out_beat && !in_beat)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_mode_reg <= SelLong;
            count_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                long_mode_reg <= cfg_data;
            end
            count_reg <= count_next;
        end
    end

    // A result is only shown while an accepted beat is still owed.
    assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> count_reg != 2'd0)
        else $error("result shown with no beat in flight");

    // The block never holds more than two beats.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg == 2'd2 |-> !op_ready
                     || res_ready)
        else $error("third beat accepted while both stages are full");

    // In 32-trit mode the upper halves of every result plane are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
                     res_valid && long_mode_reg == SelShort
                     |-> res_data.out_first_plane0[LongTrits-1:ShortTrits] == '0
                      && res_data.out_first_plane1[LongTrits-1:ShortTrits] == '0
                      && res_data.out_second_plane0[LongTrits-1:ShortTrits] == '0
                      && res_data.out_second_plane1[LongTrits-1:ShortTrits] == '0)
        else $error("upper trits set in 32-trit mode");

    assert property (@(posedge clk) disable iff (!rst_n) res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
                     res_valid && !res_ready |=> $stable(res_data))
        else $error("stalled result changed");

endmodule

bind gf3_negacyclic_butterfly_core gf3nb_checker u_gf3nb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (operands.valid),
    .op_ready  (operands.ready),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_data  (cfg.data)
);
